FILE: rtl/evih_pkg.sv
// ----------------------------------------------------------------------------
// evih_pkg: shared constants and the VLAN tag test of the Ethernet VLAN/IP flow hash
// Ethertype codes, header offsets, address windows and result kinds.
// ----------------------------------------------------------------------------
package evih_pkg;

  localparam int POSITION_BITS_DEF = 16;

  localparam logic [15:0] TYPE_CTAG = 16'h8100;
  localparam logic [15:0] TYPE_STAG = 16'h88A8;
  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] TYPE_IPV6 = 16'h86DD;

  // Byte positions of the ethertype fields.
  localparam int OFF_OUTER_TYPE = 12;
  localparam int OFF_TAG_TYPE   = 16;
  localparam int OFF_INNER_TYPE = 20;

  // Network header offsets for zero, one and two tags.
  localparam logic [4:0] HDR_OFF_UNTAGGED = 5'd14;
  localparam logic [4:0] HDR_OFF_SINGLE   = 5'd18;
  localparam logic [4:0] HDR_OFF_DOUBLE   = 5'd22;

  // Address windows relative to the network header.
  localparam int V4_ADDR_START = 12;
  localparam int V4_DST_START  = 16;
  localparam int V4_ADDR_END   = 20;
  localparam int V6_ADDR_START = 8;
  localparam int V6_DST_START  = 24;
  localparam int V6_ADDR_END   = 40;

  localparam logic [1:0] KIND_IPV4  = 2'd0;
  localparam logic [1:0] KIND_IPV6  = 2'd1;
  localparam logic [1:0] KIND_OTHER = 2'd2;
  localparam logic [1:0] KIND_TRUNC = 2'd3;

  localparam logic [1:0] LANE_LAST = 2'd3;

  function automatic logic is_tag(input logic [15:0] t);
    return (t == TYPE_CTAG) || (t == TYPE_STAG);
  endfunction

endpackage

FILE: rtl/evih_if.sv
// ----------------------------------------------------------------------------
// evih_in_if / evih_out_if: valid/ready channels of the flow hash unit
// One interface for the frame byte stream, one for the hash results.
// ----------------------------------------------------------------------------
interface evih_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
  modport mon    (input valid, input data_byte, input last, input ready);
endinterface

interface evih_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] flow_hash;
  logic [1:0]  packet_kind;

  modport source (output valid, output flow_hash, output packet_kind, input ready);
  modport sink   (input valid, input flow_hash, input packet_kind, output ready);
  modport mon    (input valid, input flow_hash, input packet_kind, input ready);
endinterface

FILE: rtl/ethernet_vlan_ip_flow_hash_unit.sv
// ----------------------------------------------------------------------------
// ethernet_vlan_ip_flow_hash_unit: symmetric IP address flow hash
// Parses an Ethernet frame byte by byte, skips up to two VLAN tags and
// folds the IPv4 or IPv6 addresses into a 16-bit hash given on the last byte.
//
//   channel   direction  request payload
//   in_chan   sink       data_byte[7:0], last
//   out_chan  source     flow_hash[15:0], packet_kind[1:0]
//
// One byte is accepted every cycle unless stalled. A byte goes through an input
// register and its result, if it is a last byte, is written to the output
// register when the byte leaves the input register. The only stall is a last byte
// waiting in the input register while the output register still holds an
// untaken result.
// Synchronous active-low reset clears the parser state and both valid flags.
// ----------------------------------------------------------------------------
module ethernet_vlan_ip_flow_hash_unit #(
  parameter int POSITION_BITS = evih_pkg::POSITION_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  evih_in_if.sink    in_chan,
  evih_out_if.source out_chan
);
  import evih_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // Parser state. Only the low 16 bits of the address words reach the hash,
  // so the assembly and accumulators keep just those lanes.
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [15:0] outer_r, outer_nxt;
  logic [15:0] tag_r, tag_nxt;
  logic [15:0] net_r, net_nxt;
  logic [4:0]  hdr_r, hdr_nxt;
  logic [15:0] word_r, word_nxt;
  logic [15:0] src_r, src_nxt;
  logic [15:0] dst_r, dst_nxt;

  // Output register.
  logic        out_valid_r;
  logic [15:0] out_hash_r, hash_nxt;
  logic [1:0]  out_kind_r, kind_nxt;

  logic stall;
  logic fire;

  logic [POSITION_BITS-1:0] rel;
  logic [15:0] word_tmp;
  logic        in_v4, in_v6;
  logic        trunc;

  assign stall = s1_valid_r && s1_last_r && out_valid_r && !out_chan.ready;
  assign fire  = s1_valid_r && !stall;
  assign in_chan.ready = !stall;

  always_comb begin
    pos_nxt   = (pos_r == POS_MAX) ? pos_r : pos_r + POSITION_BITS'(1);
    outer_nxt = outer_r;
    tag_nxt   = tag_r;
    net_nxt   = net_r;
    hdr_nxt   = hdr_r;
    word_nxt  = word_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    rel       = '0;
    word_tmp  = '0;
    in_v4     = 1'b0;
    in_v6     = 1'b0;

    if (pos_r == POSITION_BITS'(OFF_OUTER_TYPE)) begin
      outer_nxt = {s1_byte_r, 8'h00};
    end else if (pos_r == POSITION_BITS'(OFF_OUTER_TYPE + 1)) begin
      outer_nxt = {outer_r[15:8], s1_byte_r};
      net_nxt   = {outer_r[15:8], s1_byte_r};
      hdr_nxt   = HDR_OFF_UNTAGGED;
    end else if (is_tag(outer_r) && pos_r == POSITION_BITS'(OFF_TAG_TYPE)) begin
      tag_nxt = {s1_byte_r, 8'h00};
    end else if (is_tag(outer_r) && pos_r == POSITION_BITS'(OFF_TAG_TYPE + 1)) begin
      tag_nxt = {tag_r[15:8], s1_byte_r};
      if (is_tag({tag_r[15:8], s1_byte_r})) begin
        hdr_nxt = HDR_OFF_DOUBLE;
      end else begin
        hdr_nxt = HDR_OFF_SINGLE;
        net_nxt = {tag_r[15:8], s1_byte_r};
      end
    end else if (is_tag(outer_r) && is_tag(tag_r)
                 && pos_r == POSITION_BITS'(OFF_INNER_TYPE)) begin
      net_nxt = {s1_byte_r, 8'h00};
    end else if (is_tag(outer_r) && is_tag(tag_r)
                 && pos_r == POSITION_BITS'(OFF_INNER_TYPE + 1)) begin
      net_nxt = {net_r[15:8], s1_byte_r};
    end

    // Address gathering uses the offset and type as updated by this byte.
    if (pos_r >= POSITION_BITS'(HDR_OFF_UNTAGGED)
        && pos_r >= POSITION_BITS'(hdr_nxt)) begin
      rel   = pos_r - POSITION_BITS'(hdr_nxt);
      in_v4 = (net_nxt == TYPE_IPV4) && rel >= POSITION_BITS'(V4_ADDR_START)
              && rel < POSITION_BITS'(V4_ADDR_END);
      in_v6 = (net_nxt == TYPE_IPV6) && rel >= POSITION_BITS'(V6_ADDR_START)
              && rel < POSITION_BITS'(V6_ADDR_END);
      if (in_v4 || in_v6) begin
        word_tmp = word_r;
        case (rel[1:0])
          2'd2:    word_tmp[15:8] = s1_byte_r;
          2'd3:    word_tmp[7:0]  = s1_byte_r;
          default: word_tmp = word_r;
        endcase
        word_nxt = word_tmp;
        if (rel[1:0] == LANE_LAST || s1_last_r) begin
          if (in_v4) begin
            if (rel < POSITION_BITS'(V4_DST_START)) src_nxt = src_r | word_tmp;
            else                                     dst_nxt = dst_r | word_tmp;
          end else begin
            if (rel < POSITION_BITS'(V6_DST_START)) src_nxt = src_r ^ word_tmp;
            else                                     dst_nxt = dst_r ^ word_tmp;
          end
          word_nxt = '0;
        end
      end
    end

    trunc = (pos_r < POSITION_BITS'(HDR_OFF_UNTAGGED - 5'd1))
         || (is_tag(outer_nxt) && pos_r < POSITION_BITS'(HDR_OFF_SINGLE - 5'd1))
         || (is_tag(outer_nxt) && is_tag(tag_nxt)
             && pos_r < POSITION_BITS'(HDR_OFF_DOUBLE - 5'd1));

    if (trunc) begin
      hash_nxt = '0;
      kind_nxt = KIND_TRUNC;
    end else if (net_nxt == TYPE_IPV4) begin
      hash_nxt = src_nxt + dst_nxt;
      kind_nxt = KIND_IPV4;
    end else if (net_nxt == TYPE_IPV6) begin
      hash_nxt = src_nxt + dst_nxt;
      kind_nxt = KIND_IPV6;
    end else begin
      hash_nxt = outer_nxt;
      kind_nxt = KIND_OTHER;
    end

    // The frame ends here: the next byte starts a fresh frame.
    if (s1_last_r) begin
      pos_nxt   = '0;
      outer_nxt = '0;
      tag_nxt   = '0;
      net_nxt   = '0;
      hdr_nxt   = HDR_OFF_UNTAGGED;
      word_nxt  = '0;
      src_nxt   = '0;
      dst_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_byte_r <= in_chan.data_byte;
      s1_last_r <= in_chan.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      outer_r <= '0;
      tag_r   <= '0;
      net_r   <= '0;
      hdr_r   <= HDR_OFF_UNTAGGED;
      word_r  <= '0;
      src_r   <= '0;
      dst_r   <= '0;
    end else if (fire) begin
      pos_r   <= pos_nxt;
      outer_r <= outer_nxt;
      tag_r   <= tag_nxt;
      net_r   <= net_nxt;
      hdr_r   <= hdr_nxt;
      word_r  <= word_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_last_r) begin
      out_hash_r <= hash_nxt;
      out_kind_r <= kind_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.flow_hash   = out_hash_r;
  assign out_chan.packet_kind = out_kind_r;

endmodule

FILE: rtl/evih_checker.sv
// ----------------------------------------------------------------------------
// evih_checker: port-level checks of the flow hash unit
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module evih_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_flow_hash,
  input logic [1:0]  out_packet_kind
);
  import evih_pkg::*;

  // A pending result must hold while the consumer stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_flow_hash) && $stable(out_packet_kind))
    else $error("result changed while stalled");

  // Input backpressure only comes from a full, stalled output register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // A truncated frame always carries a zero hash.
  a_trunc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_packet_kind == KIND_TRUNC |-> out_flow_hash == 16'h0)
    else $error("truncated frame with nonzero hash");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ethernet_vlan_ip_flow_hash_unit evih_checker u_evih_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_flow_hash   (out_chan.flow_hash),
  .out_packet_kind (out_chan.packet_kind)
);

FILE: sim/ethernet_vlan_ip_flow_hash_unit_tb.sv
// ----------------------------------------------------------------------------
// ethernet_vlan_ip_flow_hash_unit_tb: self-checking bench for the flow hash unit
// Streams directed and random Ethernet frames (untagged, single and double
// tagged, IPv4, IPv6, other types, truncated frames, noise and one frame that
// runs well past the address fields) and checks every hash and packet kind
// against a predictor that follows the accepted byte stream.
// ----------------------------------------------------------------------------
module ethernet_vlan_ip_flow_hash_unit_tb;
  import evih_pkg::*;

  localparam int          POS_BITS  = POSITION_BITS_DEF;
  localparam int unsigned POS_LIMIT = (1 << POS_BITS) - 1;
  localparam int          LONG_LEN  = 160;

  typedef logic [7:0] byte_queue_t[$];

  typedef struct packed {
    logic [15:0] hash;
    logic [1:0]  kind;
  } hash_result_t;

  class flow_hash_scoreboard;
    int unsigned    frame_pos;
    logic [15:0]    eth_type;
    logic [15:0]    tag_inner;
    logic [15:0]    l3_type;
    logic [4:0]     l3_offset;
    logic [31:0]    addr_word;
    logic [31:0]    src_fold;
    logic [31:0]    dst_fold;
    hash_result_t   pending_hashes[$];
    int             mismatches;

    function new();
      mismatches = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      frame_pos = 0;
      eth_type  = '0;
      tag_inner = '0;
      l3_type   = '0;
      l3_offset = HDR_OFF_UNTAGGED;
      addr_word = '0;
      src_fold  = '0;
      dst_fold  = '0;
    endfunction

    function bit is_vlan_type(logic [15:0] t);
      return (t == TYPE_CTAG) || (t == TYPE_STAG);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      mismatches++;
    endtask

    // Follows one accepted frame byte; queues the hash when it closes a frame.
    function void take_frame_byte(logic [7:0] b, logic is_last);
      int unsigned  p;
      int unsigned  r;
      int unsigned  len;
      bit           v4;
      bit           v6;
      bit           cut_short;
      logic [1:0]   lane;
      logic [31:0]  sum;
      hash_result_t res;
      p = frame_pos;
      if (frame_pos < POS_LIMIT) frame_pos++;

      if (p == OFF_OUTER_TYPE) begin
        eth_type = {b, 8'h00};
      end else if (p == OFF_OUTER_TYPE + 1) begin
        eth_type[7:0] = b;
        l3_type   = eth_type;
        l3_offset = HDR_OFF_UNTAGGED;
      end else if (is_vlan_type(eth_type) && p == OFF_TAG_TYPE) begin
        tag_inner = {b, 8'h00};
      end else if (is_vlan_type(eth_type) && p == OFF_TAG_TYPE + 1) begin
        tag_inner[7:0] = b;
        if (is_vlan_type(tag_inner)) begin
          l3_offset = HDR_OFF_DOUBLE;
        end else begin
          l3_offset = HDR_OFF_SINGLE;
          l3_type   = tag_inner;
        end
      end else if (is_vlan_type(eth_type) && is_vlan_type(tag_inner) &&
                   p == OFF_INNER_TYPE) begin
        l3_type = {b, 8'h00};
      end else if (is_vlan_type(eth_type) && is_vlan_type(tag_inner) &&
                   p == OFF_INNER_TYPE + 1) begin
        l3_type[7:0] = b;
      end

      if (p >= HDR_OFF_UNTAGGED && p >= l3_offset) begin
        r  = p - l3_offset;
        v4 = (l3_type == TYPE_IPV4) && r >= V4_ADDR_START && r < V4_ADDR_END;
        v6 = (l3_type == TYPE_IPV6) && r >= V6_ADDR_START && r < V6_ADDR_END;
        if (v4 || v6) begin
          lane = r[1:0];
          addr_word = addr_word | (32'(b) << (8 * (3 - lane)));
          // A word cut off by the end of the frame is folded with its
          // missing bytes as zero.
          if (lane == LANE_LAST || is_last) begin
            if (v4) begin
              if (r < V4_DST_START) src_fold = src_fold | addr_word;
              else                  dst_fold = dst_fold | addr_word;
            end else begin
              if (r < V6_DST_START) src_fold = src_fold ^ addr_word;
              else                  dst_fold = dst_fold ^ addr_word;
            end
            addr_word = '0;
          end
        end
      end

      if (!is_last) return;

      len = p + 1;
      cut_short = (len < 14) ||
                  (is_vlan_type(eth_type) && len < 18) ||
                  (is_vlan_type(eth_type) && is_vlan_type(tag_inner) && len < 22);
      sum = src_fold + dst_fold;
      if (cut_short) begin
        res.hash = '0;
        res.kind = KIND_TRUNC;
      end else if (l3_type == TYPE_IPV4) begin
        res.hash = sum[15:0];
        res.kind = KIND_IPV4;
      end else if (l3_type == TYPE_IPV6) begin
        res.hash = sum[15:0];
        res.kind = KIND_IPV6;
      end else begin
        res.hash = eth_type;
        res.kind = KIND_OTHER;
      end
      pending_hashes.push_back(res);
      restart_frame();
    endfunction

    task compare_hash_result(logic [15:0] hash, logic [1:0] kind);
      hash_result_t want;
      if (pending_hashes.size() == 0) begin
        report_mismatch($sformatf("unexpected result hash=%h kind=%0d", hash, kind));
        return;
      end
      want = pending_hashes.pop_front();
      if (hash !== want.hash)
        report_mismatch($sformatf("flow_hash %h, expected %h", hash, want.hash));
      if (kind !== want.kind)
        report_mismatch($sformatf("packet_kind %0d, expected %0d", kind, want.kind));
    endtask
  endclass

  logic clk;
  logic rst_n = 1'b0;

  evih_in_if  in_chan();
  evih_out_if out_chan();

  ethernet_vlan_ip_flow_hash_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  flow_hash_scoreboard hash_board = new();

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit hold_req  = 1'b0;
  int bytes_sent = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      hash_board.compare_hash_result(out_chan.flow_hash, out_chan.packet_kind);
    if (rst_n && in_chan.valid && in_chan.ready)
      hash_board.take_frame_byte(in_chan.data_byte, in_chan.last);
  end

  // Result side: random back-pressure, plus a long counted hold-off on request.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (rx_steady) begin
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= 26);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic is_last);
    if (!tx_steady && $urandom_range(99) < 26) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.data_byte <= b;
    in_chan.last      <= is_last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input byte_queue_t f);
    foreach (f[i]) push_byte(f[i], i == f.size() - 1);
  endtask

  task automatic wait_for_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (hash_board.pending_hashes.size() != 0) @(posedge clk);
  endtask

  task automatic send_filled_frame(input int len, input logic [7:0] fill,
                                   input logic [15:0] etype);
    byte_queue_t f;
    repeat (len) f.push_back(fill);
    if (len >= 14) begin
      f[12] = etype[15:8];
      f[13] = etype[7:0];
    end
    send_frame(f);
  endtask

  // Mostly well-formed frames with random content; some are cut short and
  // some are plain noise.
  task automatic send_random_frame(input int max_noise);
    byte_queue_t f;
    int          tags;
    int          full_len;
    int          cut;
    int          sel;
    logic [15:0] net;
    logic [15:0] tag_v;
    sel = $urandom_range(99);
    if (sel < 12 || max_noise < 30) begin
      repeat ($urandom_range(1, max_noise)) f.push_back(8'($urandom));
    end else begin
      tags = $urandom_range(2);
      sel  = $urandom_range(99);
      net  = (sel < 40) ? TYPE_IPV4 : (sel < 75) ? TYPE_IPV6 : 16'($urandom);
      full_len = 14 + 4 * tags + $urandom_range(6) +
                 ((net == TYPE_IPV4) ? 20 : (net == TYPE_IPV6) ? 40 : $urandom_range(8));
      repeat (full_len) f.push_back(8'($urandom));
      for (int i = 0; i < tags; i++) begin
        tag_v = $urandom_range(1) ? TYPE_CTAG : TYPE_STAG;
        f[12 + 4 * i] = tag_v[15:8];
        f[13 + 4 * i] = tag_v[7:0];
      end
      f[12 + 4 * tags] = net[15:8];
      f[13 + 4 * tags] = net[7:0];
      if ($urandom_range(99) < 35) begin
        cut = $urandom_range(1, full_len - 1);
        while (f.size() > cut) void'(f.pop_back());
      end
    end
    send_frame(f);
  endtask

  initial begin : stimulus
    byte_queue_t long_frame;
    int          frames;
    in_chan.valid     = 1'b0;
    in_chan.data_byte = '0;
    in_chan.last      = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Truncated at one byte and one short of the ethertype, then a minimal
    // frame with the largest ethertype.
    send_filled_frame(1, 8'h00, 16'h0000);
    send_filled_frame(13, 8'hFF, 16'hFFFF);
    send_filled_frame(14, 8'hFF, 16'hFFFF);

    frames = 0;
    while (bytes_sent < 1250 || frames < 32) begin
      tx_steady = (frames >= 8 && frames < 20);
      rx_steady = tx_steady;
      if (frames == 25) begin
        // Short frames while the result side is held off fill the block.
        hold_req = 1'b1;
        repeat (20) send_random_frame(3);
      end
      if (frames == 30) wait_for_results();
      send_random_frame(30);
      frames++;
    end

    // A long IPv4 frame with payload far beyond the address fields.
    repeat (LONG_LEN) long_frame.push_back(8'($urandom));
    long_frame[12] = TYPE_IPV4[15:8];
    long_frame[13] = TYPE_IPV4[7:0];
    send_frame(long_frame);
    send_random_frame(30);

    wait_for_results();
    repeat (20) @(posedge clk);
    if (hash_board.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: ethernet_vlan_ip_flow_hash_unit.f
rtl/evih_pkg.sv
rtl/evih_if.sv
rtl/ethernet_vlan_ip_flow_hash_unit.sv
rtl/evih_checker.sv
sim/ethernet_vlan_ip_flow_hash_unit_tb.sv
